>>> src/kmdr_pkg.sv
package kmdr_pkg;

   localparam int ROW_COUNT_DEF    = 4;
   localparam int COLUMN_COUNT_DEF = 5;
   localparam int REPORT_SLOTS_DEF = 6;

   // report format limits (fixed by the HID boot report)
   localparam int MAX_SLOTS = 6;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd5000;
   localparam logic [23:0] HOLD_RESET     = 24'd300000;
   localparam logic [7:0]  LEFT_SHIFT_MOD = 8'h02;

   // register indexes
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_HOLD     = 1'b1;

   typedef enum logic [1:0] {
      FUNC_MAP_LOAD = 2'd0,
      FUNC_SAMPLE   = 2'd1,
      FUNC_END_SCAN = 2'd2
   } func_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [4:0]  key_index;
      logic        level;
      logic [63:0] now_us;
      logic [7:0]  map_keycode;
      logic        map_shift;
   } req_type;

   typedef struct packed {
      logic [7:0] modifier;
      logic [7:0] code_0;
      logic [7:0] code_1;
      logic [7:0] code_2;
      logic [7:0] code_3;
      logic [7:0] code_4;
      logic [7:0] code_5;
      logic [2:0] code_count;
   } rsp_type;

   typedef struct packed {
      logic        pressed;
      logic [63:0] last_us;
   } key_entry_type;

   typedef struct packed {
      logic       shift;
      logic [7:0] code;
   } map_entry_type;

   typedef struct packed {
      logic       change;
      logic       repeat_hit;
      logic       level;
      logic       shift;
      logic [7:0] code;
      logic       flush;
   } coll_cmd_type;

endpackage

>>> src/key_matrix_debounce_reporter.sv
// Key matrix debounce and HID report collector. Takes one item per clock:
// map loads, key samples and end-of-scan marks, in any mix, back to back.
// An item enters a two-stage path: the accept cycle issues a read of the
// key's state and map entry (synchronous memories, registered read), the next
// cycle does the elapsed-time subtract, the debounce/hold compares and the
// write-back. Same-key items in adjacent cycles are forwarded, so there is
// no interlock. A report goes to rsp_ from an output register, loaded as its
// end of scan leaves the second stage. req_ready drops only when a report is
// still held in that register, rsp_ready is low and the item in the second
// stage is an end of scan that must emit. Key state resets through per-key
// valid bits, so there is no clearing pass after reset; the key map is
// undefined until loaded. Registers on csr_: index 0 debounce time (16 bit,
// reset 5000 us), index 1 hold time (24 bit, reset 300000 us); write them
// only while idle.
module key_matrix_debounce_reporter #(
   parameter int ROW_COUNT    = kmdr_pkg::ROW_COUNT_DEF,
   parameter int COLUMN_COUNT = kmdr_pkg::COLUMN_COUNT_DEF,
   parameter int REPORT_SLOTS = kmdr_pkg::REPORT_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kmdr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kmdr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [23:0]       csr_wdata
);

   localparam int KEY_TOTAL = ROW_COUNT * COLUMN_COUNT;
   localparam int AW        = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;

   // config registers
   logic [15:0] debounce_ff;
   logic [23:0] hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= kmdr_pkg::DEBOUNCE_RESET;
         hold_ff     <= kmdr_pkg::HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kmdr_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata[15:0];
            kmdr_pkg::CSR_HOLD:     hold_ff     <= csr_wdata;
            default:                ;
         endcase
      end
   end

   // stage 0: accept and read
   logic          accept;
   logic          stall;
   logic [AW-1:0] rd_addr;
   logic          in_range;

   assign req_ready = !stall;
   assign accept    = req_valid && req_ready;
   assign rd_addr   = AW'(req_data.key_index);
   assign in_range  = 32'(req_data.key_index) < 32'(KEY_TOTAL);

   // stage 1: item with read data
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_range_ff;
   logic [AW-1:0]     s1_addr_ff;
   kmdr_pkg::req_type s1_req_ff;

   assign s1_valid_in = accept || (s1_valid_ff && stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req_data;
         s1_range_ff <= in_range;
         s1_addr_ff  <= rd_addr;
      end
   end

   kmdr_pkg::key_entry_type key_rd;
   kmdr_pkg::map_entry_type map_rd;
   kmdr_pkg::key_entry_type st_wr_data;
   kmdr_pkg::map_entry_type map_wr_data;
   logic                    st_wr_en;
   logic                    map_wr_en;
   logic                    is_sample;
   logic                    is_load;
   logic                    is_eos;
   logic [63:0]             elapsed;
   logic                    deb_ok;
   logic                    hold_ok;
   logic                    change;
   kmdr_pkg::coll_cmd_type  cmd;

   always_comb begin
      is_sample = 1'b0;
      is_load   = 1'b0;
      is_eos    = 1'b0;
      unique case (s1_req_ff.func)
         kmdr_pkg::FUNC_MAP_LOAD: is_load   = s1_range_ff;
         kmdr_pkg::FUNC_SAMPLE:   is_sample = s1_range_ff;
         kmdr_pkg::FUNC_END_SCAN: is_eos    = 1'b1;
         default:                 ;
      endcase
   end

   // elapsed time wraps modulo 2^64
   assign elapsed = s1_req_ff.now_us - key_rd.last_us;
   assign deb_ok  = elapsed > 64'(debounce_ff);
   assign hold_ok = elapsed > 64'(hold_ff);
   assign change  = (s1_req_ff.level != key_rd.pressed) && deb_ok;

   // a stalled item is always an end of scan, which writes nothing
   assign st_wr_en           = s1_valid_ff && is_sample && change;
   assign st_wr_data.pressed = s1_req_ff.level;
   assign st_wr_data.last_us = s1_req_ff.now_us;
   assign map_wr_en          = s1_valid_ff && is_load;
   assign map_wr_data.shift  = s1_req_ff.map_shift;
   assign map_wr_data.code   = s1_req_ff.map_keycode;

   always_comb begin
      cmd            = '0;
      cmd.change     = is_sample && change;
      cmd.repeat_hit = is_sample && !change && s1_req_ff.level && hold_ok;
      cmd.level      = s1_req_ff.level;
      cmd.shift      = map_rd.shift;
      cmd.code       = map_rd.code;
      cmd.flush      = is_eos;
   end

   kmdr_key_store #(
      .DEPTH (KEY_TOTAL),
      .AW    (AW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (accept),
      .rd_addr     (rd_addr),
      .key_rd      (key_rd),
      .map_rd      (map_rd),
      .st_wr_en    (st_wr_en),
      .st_wr_addr  (s1_addr_ff),
      .st_wr_data  (st_wr_data),
      .map_wr_en   (map_wr_en),
      .map_wr_addr (s1_addr_ff),
      .map_wr_data (map_wr_data)
   );

   kmdr_collector #(
      .REPORT_SLOTS (REPORT_SLOTS)
   ) u_coll (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (s1_valid_ff),
      .cmd       (cmd),
      .stall     (stall),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> src/kmdr_key_store.sv
// Per-key state and key map memories, one registered read port each.
module kmdr_key_store #(
   parameter int DEPTH = kmdr_pkg::ROW_COUNT_DEF * kmdr_pkg::COLUMN_COUNT_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output kmdr_pkg::key_entry_type key_rd,
   output kmdr_pkg::map_entry_type map_rd,
   input  logic                    st_wr_en,
   input  logic [AW-1:0]           st_wr_addr,
   input  kmdr_pkg::key_entry_type st_wr_data,
   input  logic                    map_wr_en,
   input  logic [AW-1:0]           map_wr_addr,
   input  kmdr_pkg::map_entry_type map_wr_data
);

   kmdr_pkg::key_entry_type key_mem [DEPTH];
   kmdr_pkg::map_entry_type map_mem [DEPTH];

   kmdr_pkg::key_entry_type key_q_ff;
   kmdr_pkg::map_entry_type map_q_ff;
   kmdr_pkg::key_entry_type st_byp_ff;
   kmdr_pkg::map_entry_type map_byp_ff;

   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic             st_hit_ff;
   logic             st_hit_in;
   logic             map_hit_ff;
   logic             map_hit_in;
   logic             vld_rd_ff;
   logic             vld_rd_in;

   always_ff @(posedge clock) begin
      if (st_wr_en) begin
         key_mem[st_wr_addr] <= st_wr_data;
      end
      if (map_wr_en) begin
         map_mem[map_wr_addr] <= map_wr_data;
      end
      if (rd_en) begin
         key_q_ff   <= key_mem[rd_addr];
         map_q_ff   <= map_mem[rd_addr];
         st_byp_ff  <= st_wr_data;
         map_byp_ff <= map_wr_data;
      end
   end

   // write in the same cycle as a read of that entry: take the new data
   always_comb begin
      valid_in   = valid_ff;
      st_hit_in  = st_hit_ff;
      map_hit_in = map_hit_ff;
      vld_rd_in  = vld_rd_ff;
      if (rd_en) begin
         st_hit_in  = st_wr_en && (st_wr_addr == rd_addr);
         map_hit_in = map_wr_en && (map_wr_addr == rd_addr);
         vld_rd_in  = valid_ff[rd_addr];
      end
      if (st_wr_en) begin
         valid_in[st_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         st_hit_ff  <= 1'b0;
         map_hit_ff <= 1'b0;
         vld_rd_ff  <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         st_hit_ff  <= st_hit_in;
         map_hit_ff <= map_hit_in;
         vld_rd_ff  <= vld_rd_in;
      end
   end

   // never-written key state reads as zero
   assign key_rd = st_hit_ff ? st_byp_ff : (vld_rd_ff ? key_q_ff : '0);
   assign map_rd = map_hit_ff ? map_byp_ff : map_q_ff;

   a_st_bypass: assert property (@(posedge clock) disable iff (reset)
      (rd_en && st_wr_en && (st_wr_addr == rd_addr)) |=> (key_rd == $past(st_wr_data)))
      else $error("key state bypass lost a same-cycle write");

endmodule

>>> src/kmdr_collector.sv
// Report collection and output register.
module kmdr_collector #(
   parameter int REPORT_SLOTS = kmdr_pkg::REPORT_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  kmdr_pkg::coll_cmd_type cmd,
   output logic                   stall,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output kmdr_pkg::rsp_type      rsp_data
);

   logic [7:0] codes_ff [REPORT_SLOTS];
   logic [7:0] codes_in [REPORT_SLOTS];
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic       shift_ff;
   logic       shift_in;
   logic       pending_ff;
   logic       pending_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   kmdr_pkg::rsp_type rsp_data_ff;
   kmdr_pkg::rsp_type report;

   logic       act;
   logic       room;
   logic       add;
   logic       shift_set;
   logic       emit;
   logic [7:0] out_codes [kmdr_pkg::MAX_SLOTS];

   assign stall = cmd_valid && cmd.flush && pending_ff && rsp_valid_ff && !rsp_ready;
   assign act   = cmd_valid && !stall;
   assign room  = count_ff < 3'(REPORT_SLOTS);
   assign add   = act && !cmd.flush && room &&
                  ((cmd.change && cmd.level) || cmd.repeat_hit);
   // a repeat that finds the slots full leaves the shift mark alone
   assign shift_set = act && !cmd.flush && cmd.shift &&
                      (cmd.change || (cmd.repeat_hit && room));
   assign emit  = act && cmd.flush && pending_ff;

   genvar g;
   generate
      for (g = 0; g < kmdr_pkg::MAX_SLOTS; g++) begin : g_slot
         if (g < REPORT_SLOTS) begin : g_used
            assign out_codes[g] = codes_ff[g];
         end else begin : g_unused
            assign out_codes[g] = 8'd0;
         end
      end
   endgenerate

   always_comb begin
      report            = '0;
      report.modifier   = (shift_ff && (count_ff != 3'd0)) ? kmdr_pkg::LEFT_SHIFT_MOD : 8'd0;
      report.code_0     = out_codes[0];
      report.code_1     = out_codes[1];
      report.code_2     = out_codes[2];
      report.code_3     = out_codes[3];
      report.code_4     = out_codes[4];
      report.code_5     = out_codes[5];
      report.code_count = count_ff;
   end

   always_comb begin
      codes_in     = codes_ff;
      count_in     = count_ff;
      shift_in     = shift_ff || shift_set;
      pending_in   = pending_ff || add;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      if (act && cmd.flush) begin
         for (int j = 0; j < REPORT_SLOTS; j++) begin
            codes_in[j] = 8'd0;
         end
         count_in = 3'd0;
         shift_in = 1'b0;
      end else if (add) begin
         for (int j = 0; j < REPORT_SLOTS; j++) begin
            if (count_ff == 3'(j)) begin
               codes_in[j] = cmd.code;
            end
         end
         count_in = count_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < REPORT_SLOTS; j++) begin
            codes_ff[j] <= 8'd0;
         end
         count_ff     <= 3'd0;
         shift_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         codes_ff     <= codes_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= report;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(REPORT_SLOTS))
      else $error("collection count past slot total");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (act && cmd.flush) |=> (count_ff == 3'd0) && !shift_ff)
      else $error("end of scan left collection state");

   a_pending_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(pending_ff))
      else $error("pending flag cleared");

   a_emit_loaded: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && (rsp_data_ff.code_count == $past(count_ff)))
      else $error("report not loaded into output register");

endmodule

>>> bench/key_matrix_debounce_reporter_tb.sv
module key_matrix_debounce_reporter_tb;

   // Matrix geometry and report size as built into the block's defaults.
   localparam int KEY_TOTAL = kmdr_pkg::ROW_COUNT_DEF * kmdr_pkg::COLUMN_COUNT_DEF;
   localparam int SLOTS     = kmdr_pkg::REPORT_SLOTS_DEF;

   // Random part: six segments, each with its own register setting; the idle
   // pattern is set in segments 0, 2 and 4. About 1950 effective items in all.
   localparam int SEGMENTS  = 6;
   localparam int SEG_ITEMS = 325;

   // Cycles with no transfer on either channel before the run is declared hung.
   localparam int STALL_LIMIT = 3000;
   // Two pipeline stages plus the output register, with margin.
   localparam int TAIL_CYCLES = 8;
   // Cap on printed mismatch lines; all mismatches are still counted.
   localparam int PRINT_CAP   = 100;

   // func code the block does not define; it must be dropped silently.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // How a directed row gets its expectation: from the predictor, typed in
   // as "no report", or typed in as a given report.
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_NONE,
      ROW_GIVEN
   } row_kind_type;

   typedef struct {
      kmdr_pkg::req_type item;
      row_kind_type      kind;
      kmdr_pkg::rsp_type given;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // Block ports. Every input holds a known value from time zero.
   // ---------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   kmdr_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   kmdr_pkg::rsp_type rsp_data;
   logic              csr_we    = 1'b0;
   logic              csr_index = kmdr_pkg::CSR_DEBOUNCE;
   logic [23:0]       csr_wdata = '0;

   key_matrix_debounce_reporter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 unit period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the block's registers, per-key
   // debounce state, key map and the report being collected.
   // ---------------------------------------------------------------------
   logic [15:0]             deb_limit_us;
   logic [23:0]             hold_us;
   bit                      key_down   [KEY_TOTAL];
   logic [63:0]             key_stamp  [KEY_TOTAL];   // time of last accepted change
   kmdr_pkg::map_entry_type key_map    [KEY_TOTAL];
   bit                      key_mapped [KEY_TOTAL];   // samples only go to loaded keys
   logic [7:0]              held_codes [SLOTS];
   int                      held_count;
   bit                      shift_held;
   bit                      report_armed;             // sticky once any code was added

   kmdr_pkg::rsp_type       expected_reports [$];
   kmdr_pkg::rsp_type       want_rpt;
   stim_row_type            stim_table [$];

   int                      mismatches      = 0;
   int                      effective_items = 0;      // items the block acts on
   int                      stall_cycles    = 0;
   int                      send_idle_pct   = 0;
   int                      recv_idle_pct   = 0;
   logic [63:0]             scan_us;                  // microsecond time of current scan

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("mismatch @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
   endtask

   task automatic clear_held;
      for (int s = 0; s < SLOTS; s++)
         held_codes[s] = '0;
      held_count = 0;
      shift_held = 1'b0;
   endtask

   // Advances the predictor by one accepted item; emit tells whether the
   // item produces a report, rpt holds it.
   task automatic predict_report(input kmdr_pkg::req_type it, output bit emit,
                                 output kmdr_pkg::rsp_type rpt);
      int          k;
      logic [63:0] elapsed;
      emit = 1'b0;
      rpt  = '0;
      k    = int'(it.key_index);
      case (it.func)
         kmdr_pkg::FUNC_MAP_LOAD: begin
            if (k < KEY_TOTAL) begin
               key_map[k].code  = it.map_keycode;
               key_map[k].shift = it.map_shift;
               key_mapped[k]    = 1'b1;
            end
         end
         kmdr_pkg::FUNC_SAMPLE: begin
            if (k < KEY_TOTAL) begin
               // elapsed wraps modulo 2^64
               elapsed = it.now_us - key_stamp[k];
               if (it.level != key_down[k] && elapsed > 64'(deb_limit_us)) begin
                  // debounced change; releases only touch the shift mark
                  key_down[k]  = it.level;
                  key_stamp[k] = it.now_us;
                  if (key_map[k].shift)
                     shift_held = 1'b1;
                  if (it.level && held_count < SLOTS) begin
                     held_codes[held_count] = key_map[k].code;
                     held_count++;
                     report_armed = 1'b1;
                  end
               end else if (it.level && elapsed > 64'(hold_us) && held_count < SLOTS) begin
                  // held past the hold time: repeat, but not into a full report
                  if (key_map[k].shift)
                     shift_held = 1'b1;
                  held_codes[held_count] = key_map[k].code;
                  held_count++;
                  report_armed = 1'b1;
               end
            end
         end
         kmdr_pkg::FUNC_END_SCAN: begin
            if (report_armed) begin
               emit = 1'b1;
               // an empty report is all zero, shift mark or not
               if (held_count > 0) begin
                  rpt.modifier   = shift_held ? kmdr_pkg::LEFT_SHIFT_MOD : 8'h00;
                  rpt.code_0     = held_codes[0];
                  rpt.code_1     = held_codes[1];
                  rpt.code_2     = held_codes[2];
                  rpt.code_3     = held_codes[3];
                  rpt.code_4     = held_codes[4];
                  rpt.code_5     = held_codes[5];
                  rpt.code_count = 3'(held_count);
               end
            end
            clear_held();
         end
         default: ;
      endcase
   endtask

   // Offers one item on req_ and returns after its transfer. The expected
   // report, if any, is queued at the transfer edge.
   task automatic send_item(input kmdr_pkg::req_type it, input row_kind_type kind,
                            input kmdr_pkg::rsp_type given);
      bit                emit;
      kmdr_pkg::rsp_type rpt;
      int                k;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      predict_report(it, emit, rpt);
      if (kind == ROW_GIVEN)
         expected_reports.push_back(given);
      else if (kind == ROW_MODEL && emit)
         expected_reports.push_back(rpt);
      k = int'(it.key_index);
      if (it.func == kmdr_pkg::FUNC_END_SCAN ||
          ((it.func == kmdr_pkg::FUNC_MAP_LOAD || it.func == kmdr_pkg::FUNC_SAMPLE) &&
           k < KEY_TOTAL))
         effective_items++;
   endtask

   // Sender pause: drop valid, wait for every queued report, then let the
   // pipeline run empty before anything else happens.
   task automatic drain_reports;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [23:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == kmdr_pkg::CSR_DEBOUNCE)
         deb_limit_us = val[15:0];
      else
         hold_us = val;
   endtask

   function automatic kmdr_pkg::rsp_type make_report(input logic [7:0] md,
                                                     input logic [7:0] c0,
                                                     input logic [2:0] n);
      kmdr_pkg::rsp_type r;
      r            = '0;
      r.modifier   = md;
      r.code_0     = c0;
      r.code_count = n;
      return r;
   endfunction

   task automatic add_row(input logic [1:0] f, input int idx, input logic lvl,
                          input logic [63:0] t, input logic [7:0] code,
                          input logic shf, input row_kind_type kind,
                          input kmdr_pkg::rsp_type given);
      stim_row_type row;
      row.item.func        = f;
      row.item.key_index   = 5'(idx);
      row.item.level       = lvl;
      row.item.now_us      = t;
      row.item.map_keycode = code;
      row.item.map_shift   = shf;
      row.kind             = kind;
      row.given            = given;
      stim_table.push_back(row);
   endtask

   // All fields random; callers then pin down what the sequence needs.
   function automatic kmdr_pkg::req_type random_item();
      kmdr_pkg::req_type it;
      it.func        = 2'($urandom);
      it.key_index   = 5'($urandom);
      it.level       = 1'($urandom);
      it.now_us      = {$urandom, $urandom};
      it.map_keycode = 8'($urandom);
      it.map_shift   = 1'($urandom);
      return it;
   endfunction

   // Time between scans, scaled to the current register setting so that
   // bounces, accepted changes, repeats and wraps all show up.
   function automatic logic [63:0] next_gap();
      int roll;
      int h;
      roll = $urandom_range(99);
      h    = int'(hold_us);
      if (roll < 35)
         return 64'($urandom_range(int'(deb_limit_us)));
      else if (roll < 70)
         return 64'(int'(deb_limit_us) + $urandom_range(int'(deb_limit_us) + 2, 1));
      else if (roll < 95)
         return 64'($urandom_range(h + h / 2 + 2));
      else
         return {$urandom, $urandom};
   endfunction

   function automatic int mapped_key();
      int k;
      do
         k = $urandom_range(KEY_TOTAL - 1);
      while (!key_mapped[k]);
      return k;
   endfunction

   // One well-formed scan: a few samples of loaded keys at nearly the same
   // time, each keeping or flipping its level, closed by an end of scan.
   task automatic send_scan;
      int                n;
      int                k;
      kmdr_pkg::req_type it;
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
         k              = mapped_key();
         it             = random_item();
         it.func        = kmdr_pkg::FUNC_SAMPLE;
         it.key_index   = 5'(k);
         it.level       = key_down[k] ^ ($urandom_range(99) < 45);
         it.now_us      = scan_us + 64'(i);
         send_item(it, ROW_MODEL, '0);
      end
      it      = random_item();
      it.func = kmdr_pkg::FUNC_END_SCAN;
      send_item(it, ROW_MODEL, '0);
      scan_us = scan_us + next_gap();
   endtask

   // Mostly scans; the rest map reloads, dropped items, samples at random
   // times and lone end-of-scan transfers. One sender pause halfway through.
   task automatic run_segment(input int items);
      int                stop_at;
      int                roll;
      bit                paused;
      kmdr_pkg::req_type it;
      stop_at = effective_items + items;
      paused  = 1'b0;
      while (effective_items < stop_at) begin
         roll = $urandom_range(99);
         it   = random_item();
         if (roll < 80) begin
            send_scan();
         end else if (roll < 88) begin
            // key index spans the full field, so some loads are dropped
            it.func = kmdr_pkg::FUNC_MAP_LOAD;
            send_item(it, ROW_MODEL, '0);
         end else if (roll < 92) begin
            it.key_index = 5'($urandom_range(31, KEY_TOTAL));
            if (it.func == kmdr_pkg::FUNC_END_SCAN)
               it.func = kmdr_pkg::FUNC_SAMPLE;
            send_item(it, ROW_MODEL, '0);
         end else if (roll < 95) begin
            it.func = FUNC_UNUSED;
            send_item(it, ROW_MODEL, '0);
         end else if (roll < 98) begin
            it.func      = kmdr_pkg::FUNC_SAMPLE;
            it.key_index = 5'(mapped_key());
            send_item(it, ROW_MODEL, '0);
         end else begin
            it.func = kmdr_pkg::FUNC_END_SCAN;
            send_item(it, ROW_MODEL, '0);
         end
         if (!paused && stop_at - effective_items <= items / 2) begin
            drain_reports();
            paused = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: rsp_ready changes on the falling edge, transfers are checked
   // on the rising edge against the oldest queued report.
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("report transfer with none expected");
         end else begin
            want_rpt = expected_reports.pop_front();
            check_field("modifier",   rsp_data.modifier,   want_rpt.modifier);
            check_field("code_0",     rsp_data.code_0,     want_rpt.code_0);
            check_field("code_1",     rsp_data.code_1,     want_rpt.code_1);
            check_field("code_2",     rsp_data.code_2,     want_rpt.code_2);
            check_field("code_3",     rsp_data.code_3,     want_rpt.code_3);
            check_field("code_4",     rsp_data.code_4,     want_rpt.code_4);
            check_field("code_5",     rsp_data.code_5,     want_rpt.code_5);
            check_field("code_count", 8'(rsp_data.code_count), 8'(want_rpt.code_count));
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("key_matrix_debounce_reporter_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      // predictor starts from the block's reset state
      deb_limit_us = kmdr_pkg::DEBOUNCE_RESET;
      hold_us      = kmdr_pkg::HOLD_RESET;
      for (int k = 0; k < KEY_TOTAL; k++) begin
         key_down[k]   = 1'b0;
         key_stamp[k]  = '0;
         key_map[k]    = '0;
         key_mapped[k] = 1'b0;
      end
      clear_held();
      report_armed = 1'b0;
      scan_us      = '0;

      // Directed part, at reset register values (5000 us / 300000 us).
      // Nothing collected yet: end of scan gives no report.
      add_row(kmdr_pkg::FUNC_END_SCAN, 0, 1'b0, 64'd0, 8'h00, 1'b0, ROW_NONE, '0);
      // Map keys 0..5 and 19, keycode extremes 00 and FF among them.
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 0,  1'b0, 64'd0, 8'h04, 1'b0, ROW_NONE, '0);
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 1,  1'b1, 64'd0, 8'h00, 1'b0, ROW_NONE, '0);
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 2,  1'b0, 64'd0, 8'h1E, 1'b0, ROW_NONE, '0);
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 3,  1'b0, 64'd0, 8'h2C, 1'b0, ROW_NONE, '0);
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 4,  1'b0, 64'd0, 8'h39, 1'b0, ROW_NONE, '0);
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 5,  1'b0, 64'd0, 8'h2F, 1'b1, ROW_NONE, '0);
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 19, 1'b0, 64'd0, 8'hFF, 1'b1, ROW_NONE, '0);
      // Out-of-range map load and the unused func code: both dropped.
      add_row(kmdr_pkg::FUNC_MAP_LOAD, 31, 1'b1, 64'd0, 8'h55, 1'b1, ROW_NONE, '0);
      add_row(FUNC_UNUSED, 7, 1'b1, 64'h0123_4567_89AB_CDEF, 8'hA5, 1'b1, ROW_NONE, '0);
      // Press just past the debounce time is taken, exactly at it is not.
      add_row(kmdr_pkg::FUNC_SAMPLE, 0,  1'b1, 64'd5001, 8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_SAMPLE, 19, 1'b1, 64'd5000, 8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_END_SCAN, 0, 1'b0, 64'd0, 8'h00, 1'b0, ROW_GIVEN,
              make_report(8'h00, 8'h04, 3'd1));
      // Shifted key: left shift in the modifier.
      add_row(kmdr_pkg::FUNC_SAMPLE, 19, 1'b1, 64'd10000, 8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_END_SCAN, 0, 1'b0, 64'd0, 8'h00, 1'b0, ROW_GIVEN,
              make_report(kmdr_pkg::LEFT_SHIFT_MOD, 8'hFF, 3'd1));
      // Five presses, a repeat of key 0 fills the sixth slot, the repeat
      // of key 19 finds the report full.
      add_row(kmdr_pkg::FUNC_SAMPLE, 1,  1'b1, 64'd20000,  8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_SAMPLE, 2,  1'b1, 64'd20000,  8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_SAMPLE, 3,  1'b1, 64'd20000,  8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_SAMPLE, 4,  1'b1, 64'd20000,  8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_SAMPLE, 5,  1'b1, 64'd20000,  8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_SAMPLE, 0,  1'b1, 64'd400000, 8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_SAMPLE, 19, 1'b1, 64'd400000, 8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_END_SCAN, 0, 1'b0, 64'd0, 8'h00, 1'b0, ROW_MODEL, '0);
      // Pending stays set: the next end of scan sends an empty report.
      add_row(kmdr_pkg::FUNC_END_SCAN, 0, 1'b0, 64'd0, 8'h00, 1'b0, ROW_GIVEN,
              make_report(8'h00, 8'h00, 3'd0));
      // Release of a shifted key at the top of time: shift seen, but an
      // empty report carries no modifier.
      add_row(kmdr_pkg::FUNC_SAMPLE, 19, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0,
              ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_END_SCAN, 0, 1'b0, 64'd0, 8'h00, 1'b0, ROW_GIVEN,
              make_report(8'h00, 8'h00, 3'd0));
      // Press after the time wraps: elapsed is 5001.
      add_row(kmdr_pkg::FUNC_SAMPLE, 19, 1'b1, 64'd5000, 8'h00, 1'b0, ROW_MODEL, '0);
      add_row(kmdr_pkg::FUNC_END_SCAN, 0, 1'b0, 64'd0, 8'h00, 1'b0, ROW_MODEL, '0);

      send_idle_pct = 29;
      recv_idle_pct = 87;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[r])
         send_item(stim_table[r].item, stim_table[r].kind, stim_table[r].given);

      // Random part. Registers change only with the block drained.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_reports();
         case (seg)
            0: begin
               send_idle_pct = 29; recv_idle_pct = 87;
               write_csr(kmdr_pkg::CSR_DEBOUNCE, 24'd0);
               write_csr(kmdr_pkg::CSR_HOLD, 24'd0);
            end
            1: begin
               write_csr(kmdr_pkg::CSR_DEBOUNCE, 24'd65535);
               write_csr(kmdr_pkg::CSR_HOLD, 24'hFF_FFFF);
            end
            2: begin
               send_idle_pct = 87; recv_idle_pct = 29;
               write_csr(kmdr_pkg::CSR_DEBOUNCE, 24'(kmdr_pkg::DEBOUNCE_RESET));
               write_csr(kmdr_pkg::CSR_HOLD, kmdr_pkg::HOLD_RESET);
            end
            3: begin
               write_csr(kmdr_pkg::CSR_DEBOUNCE, 24'($urandom_range(65535)));
               write_csr(kmdr_pkg::CSR_HOLD, 24'($urandom));
            end
            4: begin
               send_idle_pct = 0; recv_idle_pct = 0;
               write_csr(kmdr_pkg::CSR_DEBOUNCE, 24'd20);
               write_csr(kmdr_pkg::CSR_HOLD, 24'd200);
            end
            default: begin
               write_csr(kmdr_pkg::CSR_DEBOUNCE, 24'($urandom_range(65535)));
               write_csr(kmdr_pkg::CSR_HOLD, 24'($urandom_range(4000)));
            end
         endcase
         // start small half the time, anywhere in 64 bits otherwise
         if ($urandom_range(1) == 0)
            scan_us = 64'($urandom_range(1000));
         else
            scan_us = {$urandom, $urandom};
         run_segment(SEG_ITEMS);
      end

      drain_reports();
      if (expected_reports.size() != 0)
         report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
      if (mismatches == 0)
         $display("key_matrix_debounce_reporter_tb: done, clean");
      else
         $display("key_matrix_debounce_reporter_tb: done, errors");
      $finish;
   end

endmodule

>>> sim.f
src/kmdr_pkg.sv
src/kmdr_key_store.sv
src/kmdr_collector.sv
src/key_matrix_debounce_reporter.sv
bench/key_matrix_debounce_reporter_tb.sv
